// File: hdl/fir3_pkg.sv
// Shared types and constants of the resample-by-three FIR.
// Holds the sequencer state type, the mode codes and the fixed coefficient ROM.
// No dependencies.
package fir3_pkg;

	// Coefficient format: signed Q1.17
	localparam int COEF_W    = 18;
	localparam int COEF_FRAC = 17;
	localparam int ROM_DEPTH = 48;

	// Resample mode codes
	localparam logic MODE_DECIMATE = 1'b0;
	localparam logic MODE_INTERP   = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// Hamming-windowed sinc, cutoff one third, centered on tap 24
	localparam logic signed [COEF_W-1:0] COEF_ROM [ROM_DEPTH] = '{
		18'sd0,      -18'sd132,   -18'sd158,   18'sd0,
		18'sd261,    18'sd340,    18'sd0,      -18'sd568,
		-18'sd720,   18'sd0,      18'sd1118,   18'sd1373,
		18'sd0,      -18'sd2025,  -18'sd2444,  18'sd0,
		18'sd3557,   18'sd4320,   18'sd0,      -18'sd6643,
		-18'sd8586,  18'sd0,      18'sd17899,  18'sd36095,
		18'sd43646,  18'sd35799,  18'sd17606,  18'sd0,
		-18'sd8303,  -18'sd6368,  18'sd0,      18'sd4065,
		18'sd3313,   18'sd0,      -18'sd2228,  -18'sd1824,
		18'sd0,      18'sd1204,   18'sd967,    18'sd0,
		-18'sd603,   -18'sd468,   18'sd0,      18'sd274,
		18'sd210,    18'sd0,      -18'sd138,   -18'sd126
	};

	// Coefficient of one tap; taps past the ROM weigh zero
	function automatic logic signed [COEF_W-1:0] coef_at(input int unsigned idx);
		logic signed [COEF_W-1:0] c;
		c = '0;
		if (idx < ROM_DEPTH) begin
			c = COEF_ROM[6'(idx)];
		end
		return c;
	endfunction

endpackage

// File: hdl/fir3_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the FIR sample history. No dependencies.
module fir3_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/fir_resampler_by_three.sv
// Top level of the resample-by-three FIR: sequencer, MAC pipeline, output word register.
// Depends on fir3_pkg (types, coefficient ROM) and fir3_ram (sample history).
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: in_sample
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: out_sample, tlast: last_of_run
//  cfg       in         cfg_valid/cfg_ready          cfg_data: resample_mode
//
// One filter pass is a history write, one MAC per tap through the single multiplier and the
// history RAM read port, a pipeline drain and the output load. Input words are taken only in idle.
// Decimate: a word that makes no result is only stored; one that does also runs a pass.
// Interpolate: RATE_FACTOR passes per input word, the first on the word, the later ones on stuffed zeros.
// Reset clears mode, pointers, phase and the per-entry valid bits; unwritten history reads as zero.
// A result waiting at m_axis stalls the sequencer only when the next result is ready to load.
module fir_resampler_by_three #(
	parameter int TAP_COUNT   = 48,
	parameter int RATE_FACTOR = 3,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,   // in_sample
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata,   // out_sample
	output logic                                  m_axis_tlast,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic                                  cfg_data
);

	localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int HIST_W = SAMPLE_BITS + 2;
	localparam int TAP_W  = $clog2(TAP_COUNT);
	localparam int PROD_W = HIST_W + fir3_pkg::COEF_W;
	localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT) + 1;
	localparam int Q_W    = ACC_W - fir3_pkg::COEF_FRAC;
	localparam int K_W    = $clog2(RATE_FACTOR + 1);
	localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(2 ** (fir3_pkg::COEF_FRAC - 1));
	localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	fir3_pkg::state_t state_q, state_d;

	logic                     mode_q;
	logic [TAP_W-1:0]         wptr_q;
	logic [TAP_W-1:0]         wptr_inc;
	logic [TAP_W-1:0]         rd_ptr_q;
	logic [TAP_W-1:0]         tap_q;
	logic [1:0]               phase_q;
	logic [K_W-1:0]           k_q;
	logic [TAP_COUNT-1:0]     valid_q;
	logic signed [HIST_W-1:0] push_q;
	logic signed [HIST_W-1:0] in_ext;
	logic [HIST_W-1:0]        ram_rdata;

	logic                            mac_s1, mac_s2;
	logic                            vld_s1;
	logic signed [fir3_pkg::COEF_W-1:0] coef_s1;
	logic signed [PROD_W-1:0]        prod_s2;
	logic signed [ACC_W-1:0]         acc_q;
	logic signed [ACC_W-1:0]         acc_rnd;
	logic [Q_W-1:0]                  q_val;
	logic                            q_ovf;
	logic [SAMPLE_BITS-1:0]          q_sat;

	logic [SAMPLE_BITS-1:0] out_q;
	logic                   out_last_q;
	logic                   out_valid_q;

	logic in_acc;
	logic push_en;
	logic mac_issue;
	logic out_load;
	logic tap_last;
	logic phase_hit;
	logic run_last;

	// Configuration: always ready, only bit 0 matters
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= fir3_pkg::MODE_DECIMATE;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	// Sample history
	fir3_ram #(
		.WIDTH(HIST_W),
		.DEPTH(TAP_COUNT)
	) u_hist (
		.clk  (clk),
		.we   (push_en),
		.waddr(wptr_q),
		.wdata(push_q),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	assign in_ext    = HIST_W'(signed'(s_axis_tdata[SAMPLE_BITS-1:0]));
	assign wptr_inc  = (wptr_q == TAP_W'(TAP_COUNT - 1)) ? '0 : wptr_q + 1'b1;
	assign tap_last  = (tap_q == TAP_W'(TAP_COUNT - 1));
	assign phase_hit = (phase_q >= 2'(RATE_FACTOR - 1));
	assign run_last  = (mode_q == fir3_pkg::MODE_DECIMATE) || (k_q == K_W'(RATE_FACTOR - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fir3_pkg::ST_IDLE: begin
				if (s_axis_tvalid) state_d = fir3_pkg::ST_PUSH;
			end
			fir3_pkg::ST_PUSH: begin
				if (mode_q == fir3_pkg::MODE_INTERP || phase_hit) begin
					state_d = fir3_pkg::ST_MAC;
				end else begin
					state_d = fir3_pkg::ST_IDLE;
				end
			end
			fir3_pkg::ST_MAC: begin
				if (tap_last) state_d = fir3_pkg::ST_DRAIN;
			end
			fir3_pkg::ST_DRAIN: begin
				if (!mac_s1 && !mac_s2) state_d = fir3_pkg::ST_EMIT;
			end
			fir3_pkg::ST_EMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = run_last ? fir3_pkg::ST_IDLE : fir3_pkg::ST_PUSH;
				end
			end
			default: state_d = fir3_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		s_axis_tready = 1'b0;
		push_en       = 1'b0;
		mac_issue     = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			fir3_pkg::ST_IDLE:  s_axis_tready = 1'b1;
			fir3_pkg::ST_PUSH:  push_en       = 1'b1;
			fir3_pkg::ST_MAC:   mac_issue     = 1'b1;
			fir3_pkg::ST_DRAIN: ;
			fir3_pkg::ST_EMIT:  out_load      = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	assign in_acc = s_axis_tvalid && s_axis_tready;

	// Sequencer registers: pointers, phase, tap and run counters, valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= fir3_pkg::ST_IDLE;
			wptr_q   <= '0;
			rd_ptr_q <= '0;
			tap_q    <= '0;
			phase_q  <= '0;
			k_q      <= '0;
			valid_q  <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				k_q <= '0;
			end
			// Store the word, step the write pointer and decimate phase, start a pass at the oldest entry
			if (push_en) begin
				valid_q[wptr_q] <= 1'b1;
				wptr_q          <= wptr_inc;
				rd_ptr_q        <= wptr_inc;
				tap_q           <= '0;
				if (mode_q == fir3_pkg::MODE_DECIMATE) begin
					phase_q <= phase_hit ? 2'd0 : phase_q + 2'd1;
				end
			end
			// Walk the taps
			if (mac_issue) begin
				tap_q    <= tap_q + 1'b1;
				rd_ptr_q <= (rd_ptr_q == TAP_W'(TAP_COUNT - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (out_load && !run_last) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// Word to store: input (scaled in interpolate mode), then zeros for the stuffing
	always_ff @(posedge clk) begin
		if (in_acc) begin
			push_q <= (mode_q == fir3_pkg::MODE_INTERP) ? HIST_W'(in_ext * RATE_FACTOR) : in_ext;
		end else if (out_load) begin
			push_q <= '0;
		end
	end

	// MAC pipeline flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= 1'b0;
			mac_s2 <= 1'b0;
		end else begin
			mac_s1 <= mac_issue;
			mac_s2 <= mac_s1;
		end
	end

	// Coefficient and entry valid alongside the RAM read, product, accumulate
	always_ff @(posedge clk) begin
		coef_s1 <= fir3_pkg::coef_at({{(32-TAP_W){1'b0}}, tap_q});
		vld_s1  <= valid_q[rd_ptr_q];
		prod_s2 <= (vld_s1 ? signed'(ram_rdata) : HIST_W'(0)) * coef_s1;
		if (push_en) begin
			acc_q <= '0;
		end else if (mac_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Round half up, then saturate to the sample range
	assign acc_rnd = acc_q + RND_BIAS;
	assign q_val   = acc_rnd[ACC_W-1:fir3_pkg::COEF_FRAC];
	assign q_ovf   = !((&q_val[Q_W-1:SAMPLE_BITS-1]) || !(|q_val[Q_W-1:SAMPLE_BITS-1]));
	assign q_sat   = q_ovf ? (q_val[Q_W-1] ? SAT_MIN : SAT_MAX) : q_val[SAMPLE_BITS-1:0];

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q      <= q_sat;
			out_last_q <= run_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = DATA_W'(out_q);
	assign m_axis_tlast  = out_last_q;

endmodule

// File: sim/fir3_resample_checker.sv
// Checker for the resample-by-three FIR: watches the input, output and mode-write channels,
// keeps its own filter state, predicts every output word and compares it field by field.
// Depends on fir3_pkg for the mode codes only.
`timescale 1ns / 1ps

module fir3_resample_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // in_sample
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,   // out_sample
	input  logic        m_axis_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	output int          error_count,
	output int          pending
);

	localparam int TAPS     = 48;
	localparam int RATE     = 3;
	localparam int FRAC     = 17;
	localparam int OUT_MAX  = 32767;
	localparam int OUT_MIN  = -32768;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last;
	} sample_out_t;

	// Lowpass taps, Q1.17, oldest history entry meets tap 0
	int tap_weight [TAPS] = '{
		0,      -132,   -158,   0,      261,    340,    0,      -568,
		-720,   0,      1118,   1373,   0,      -2025,  -2444,  0,
		3557,   4320,   0,      -6643,  -8586,  0,      17899,  36095,
		43646,  35799,  17606,  0,      -8303,  -6368,  0,      4065,
		3313,   0,      -2228,  -1824,  0,      1204,   967,    0,
		-603,   -468,   0,      274,    210,    0,      -138,   -126
	};

	sample_out_t        expected_samples [$];
	logic signed [17:0] history [TAPS];
	int unsigned        wr_pos;
	logic [1:0]         dec_phase;
	logic               mode;

	initial begin
		error_count = 0;
		pending     = 0;
	end

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("%0t ns checker: %s: got %h, want %h", $time, what, got, want);
		error_count++;
	endtask

	// Store one word at the write position and advance it around the ring
	task automatic store_word(input logic signed [17:0] v);
		history[wr_pos] = v;
		wr_pos = (wr_pos + 1) % TAPS;
	endtask

	// Run the filter over the ring, oldest first; round half up, then saturate
	function automatic logic signed [15:0] fir_output();
		longint acc;
		acc = 0;
		for (int i = 0; i < TAPS; i++) begin
			acc += longint'(tap_weight[i]) * longint'(history[(wr_pos + i) % TAPS]);
		end
		acc = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
		if (acc > OUT_MAX) begin
			acc = OUT_MAX;
		end
		if (acc < OUT_MIN) begin
			acc = OUT_MIN;
		end
		return 16'(acc);
	endfunction

	// Work out the output words caused by one input word
	task automatic resample_word(input logic signed [15:0] s);
		logic signed [17:0] widened;
		sample_out_t        res;
		widened = s;
		if (mode == fir3_pkg::MODE_DECIMATE) begin
			store_word(widened);
			if (dec_phase >= 2'(RATE - 1)) begin
				dec_phase = '0;
				res.sample = fir_output();
				res.last   = 1'b1;
				expected_samples.push_back(res);
			end else begin
				dec_phase = dec_phase + 2'd1;
			end
		end else begin
			store_word(widened * 18'sd3);
			for (int k = 0; k < RATE; k++) begin
				if (k > 0) begin
					store_word('0);
				end
				res.sample = fir_output();
				res.last   = (k == RATE - 1);
				expected_samples.push_back(res);
			end
		end
	endtask

	// Check outputs before taking new inputs: a word accepted now cannot answer itself
	always @(posedge clk or negedge arst_n) begin
		sample_out_t want;
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				history[i] = '0;
			end
			wr_pos    = 0;
			dec_phase = '0;
			mode      = fir3_pkg::MODE_DECIMATE;
			expected_samples.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_samples.size() == 0) begin
					report_mismatch("output word with none expected", m_axis_tdata, '0);
				end else begin
					want = expected_samples.pop_front();
					if (m_axis_tdata !== want.sample) begin
						report_mismatch("out_sample", m_axis_tdata, want.sample);
					end
					if (m_axis_tlast !== want.last) begin
						report_mismatch("last_of_run", 16'(m_axis_tlast), 16'(want.last));
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				resample_word(s_axis_tdata);
			end
			if (cfg_valid && cfg_ready) begin
				mode = cfg_data;
			end
		end
		pending = expected_samples.size();
	end

endmodule

// File: sim/fir_resampler_by_three_tb.sv
// Testbench top for fir_resampler_by_three: clock, reset, input and mode-write stimulus,
// output back-pressure, watchdog and verdict. Depends on fir3_pkg and fir3_resample_checker.
`timescale 1ns / 1ps

module fir_resampler_by_three_tb;

	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 200;
	localparam int STALL_LIMIT = 3000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;
	int          error_count;
	int          pending;

	logic        mode_now;
	int          dec_sent;
	int          burst_left;
	bit          hold_request;
	int          hold_left;
	logic [15:0] ready_pattern;

	fir_resampler_by_three u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	fir3_resample_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.error_count   (error_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: rotate a back-pressure pattern, reload it now and then; long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		hold_left     = 0;
		ready_pattern = '1;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else begin
				if ($urandom_range(0, 63) == 0) begin
					case ($urandom_range(0, 3))
						0: ready_pattern = '1;
						1: ready_pattern = 16'($urandom);
						2: ready_pattern = 16'($urandom | $urandom);
						default: ready_pattern = 16'($urandom & $urandom);
					endcase
				end
				m_axis_tready <= ready_pattern[0];
				ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
			end
		end
	end

	// Watchdog: end the run after too many cycles without any accepted word
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("fir_resampler_by_three_tb: done, errors");
		$finish;
	end

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Offer one word in bursts of random length, with random gaps between bursts
	task automatic send_sample(input logic [15:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		do @(posedge clk); while (!s_axis_tready);
		if (mode_now == fir3_pkg::MODE_DECIMATE) begin
			dec_sent++;
		end
	endtask

	// Drop valid, wait for every expected word, then let the block go quiet
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_mode(input logic m);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		mode_now = m;
	endtask

	// Decimate: 48 words whose signs follow the taps, aligned so the last one yields an
	// output; drives the sum past full scale. Zero taps get random content.
	task automatic send_matched(input bit to_max);
		int pol;
		logic [15:0] v;
		repeat ((3 - dec_sent % 3) % 3) send_sample(rand_sample());
		for (int i = 0; i < 48; i++) begin
			if (i >= 22 && i <= 26) begin
				pol = 1;
			end else if (i % 3 == 0) begin
				pol = 0;
			end else begin
				pol = (i % 6 < 3) ? -1 : 1;
				if (i > 26) begin
					pol = -pol;
				end
			end
			if (!to_max) begin
				pol = -pol;
			end
			if (pol > 0) begin
				v = 16'(32767 - $urandom_range(0, 255));
			end else if (pol < 0) begin
				v = 16'(-32768 + $urandom_range(0, 255));
			end else begin
				v = rand_sample();
			end
			send_sample(v);
		end
	endtask

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_data      = fir3_pkg::MODE_DECIMATE;
		mode_now      = fir3_pkg::MODE_DECIMATE;
		dec_sent      = 0;
		burst_left    = 0;
		hold_request  = 1'b0;
		arst_n        = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Decimate extremes; eight words leave the phase one short of an output
		write_mode(fir3_pkg::MODE_DECIMATE);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'h0001);
		send_sample(16'h5555);
		send_sample(16'hAAAA);
		send_sample(16'h7FFF);
		settle();

		// Interpolate extremes over the kept history
		write_mode(fir3_pkg::MODE_INTERP);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0000);
		send_sample(16'h7FFF);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0001);
		settle();

		// Back to decimate: the carried phase makes the first word yield an output
		write_mode(fir3_pkg::MODE_DECIMATE);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'h7FFE);

		// Random decimate with a positive full-scale run
		repeat (5) send_sample(rand_sample());
		send_matched(1'b1);
		repeat (8) send_sample(rand_sample());
		settle();

		// Random interpolate with one long receiver hold-off
		write_mode(fir3_pkg::MODE_INTERP);
		repeat (5) send_sample(rand_sample());
		hold_request = 1'b1;
		repeat (20) send_sample(rand_sample());
		settle();

		// Random decimate with a negative full-scale run, under a hold-off
		write_mode(fir3_pkg::MODE_DECIMATE);
		hold_request = 1'b1;
		send_matched(1'b0);
		repeat (12) send_sample(rand_sample());
		settle();

		if (error_count == 0) begin
			$display("fir_resampler_by_three_tb: done, clean");
		end else begin
			$display("fir_resampler_by_three_tb: done, errors");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/fir3_pkg.sv
hdl/fir3_ram.sv
hdl/fir_resampler_by_three.sv
sim/fir3_resample_checker.sv
sim/fir_resampler_by_three_tb.sv
